### design/kmhq_pkg.sv
// ----------------------------------------------------------------------------
// kmhq_pkg
// Shared codes and fixed field widths for the k-ary min-heap queue
// ----------------------------------------------------------------------------
package kmhq_pkg;

  // fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned ARITY_W = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // arity after reset
  localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

endpackage

### design/kmhq_in_if.sv
// ----------------------------------------------------------------------------
// kmhq_in_if
// Operation channel: valid/ready with operation, key and payload
// ----------------------------------------------------------------------------
interface kmhq_in_if #(
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [kmhq_pkg::OP_W-1:0]    operation;
  logic [KEY_BITS-1:0]          key;
  logic [PAYLOAD_BITS-1:0]      payload;

  modport source (output valid, output operation, output key, output payload, input ready);
  modport sink   (input valid, input operation, input key, input payload, output ready);
endinterface

### design/kmhq_out_if.sv
// ----------------------------------------------------------------------------
// kmhq_out_if
// Result channel: valid/ready with status, minimum entry and count
// ----------------------------------------------------------------------------
interface kmhq_out_if #(
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [kmhq_pkg::STAT_W-1:0]   status;
  logic [KEY_BITS-1:0]           out_key;
  logic [PAYLOAD_BITS-1:0]       out_payload;
  logic [kmhq_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output out_key, output out_payload,
                  output count, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input count, output ready);
endinterface

### design/kary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// kary_min_heap_queue_top
// Min-priority queue held as a k-ary heap in one RAM, run by a sequencer
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per beat (insert, extract minimum, peek);
//   out_o returns exactly one result beat per operation: status, minimum
//   entry (zero unless extract or peek succeeded) and the count afterwards.
//   cfg_we_i/cfg_wdata_i set the arity k; 0 acts as 1, large values saturate
//   at MAX_ARITY. Write it only while the block is idle.
//   One operation at a time: in_i.ready is low from acceptance until its
//   result has been taken. Entries sit in one RAM with one read and one
//   write port: insert reads one parent per level, extract each child in turn.
//   Refused, empty or unused operations: result registered at acceptance;
//   peek: result from S_RD_ROOT. Insert: S_UP_CHK, S_UP_DIV and S_UP_CMP
//   per parent compared, the parent index coming from a bit-serial
//   divider. Extract: S_RD_ROOT; if entries remain, S_RD_LAST, then per
//   level S_DN_GO, S_DN_RD and S_DN_CMP per child, and S_DN_END.
//   Reset empties the queue and sets the arity to 2; RAM contents are
//   left as they are. A stalled result holds out_o and keeps in_i.ready low.
// ----------------------------------------------------------------------------
module kary_min_heap_queue_top #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 16,
  parameter int unsigned MAX_ARITY    = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kmhq_pkg::ARITY_W-1:0]    cfg_wdata_i,
  kmhq_in_if.sink                         in_i,
  kmhq_out_if.source                      out_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = IW + kmhq_pkg::ARITY_W + 1;
  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned AW = kmhq_pkg::ARITY_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CHK  = 4'd1;
  localparam logic [3:0] S_UP_DIV  = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_RD_ROOT = 4'd4;
  localparam logic [3:0] S_RD_LAST = 4'd5;
  localparam logic [3:0] S_DN_GO   = 4'd6;
  localparam logic [3:0] S_DN_RD   = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_DN_END  = 4'd9;

  logic [3:0]                    state_q, state_d;
  logic [AW-1:0]                 arity_q;
  logic [AW-1:0]                 k_q, k_d;
  logic [kmhq_pkg::OP_W-1:0]     op_q, op_d;
  logic [EW-1:0]                 ent_q, ent_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [IW-1:0]                 hole_q, hole_d;
  logic [XW-1:0]                 c_q, c_d;
  logic [AW:0]                   j_q, j_d;
  logic                          found_q, found_d;
  logic [EW-1:0]                 best_q, best_d;
  logic [IW-1:0]                 bidx_q, bidx_d;
  logic                          ovld_q, ovld_d;
  logic [kmhq_pkg::STAT_W-1:0]   ost_q, ost_d;
  logic [EW-1:0]                 oent_q, oent_d;
  logic [kmhq_pkg::COUNT_W-1:0]  ocnt_q, ocnt_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          div_start, div_done;
  logic [IW-1:0] div_quot;
  logic [AW-1:0] eff_k;
  logic          in_acc;

  // entry store
  kmhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // parent index divider
  kmhq_div #(.W(IW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hole_q - IW'(1)),
    .divisor_i  (k_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // effective arity
  always_comb begin
    if (arity_q == '0) begin
      eff_k = AW'(1);
    end else if (int'(arity_q) > int'(MAX_ARITY)) begin
      eff_k = AW'(MAX_ARITY);
    end else begin
      eff_k = arity_q;
    end
  end

  assign in_acc = in_i.valid && in_i.ready;

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    op_d      = op_q;
    ent_d     = ent_q;
    cnt_d     = cnt_q;
    hole_d    = hole_q;
    c_d       = c_q;
    j_d       = j_q;
    found_d   = found_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    ovld_d    = ovld_q;
    ost_d     = ost_q;
    oent_d    = oent_q;
    ocnt_d    = ocnt_q;
    ram_we    = 1'b0;
    ram_waddr = hole_q;
    ram_wdata = ent_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    div_start = 1'b0;

    if (out_o.valid && out_o.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          k_d    = eff_k;
          op_d   = in_i.operation;
          ent_d  = {in_i.key, in_i.payload};
          ost_d  = kmhq_pkg::ST_OK;
          oent_d = '0;
          ocnt_d = kmhq_pkg::COUNT_W'(cnt_q);
          if (in_i.operation == kmhq_pkg::OP_INSERT) begin
            if (int'(cnt_q) >= int'(CAPACITY)) begin
              ost_d  = kmhq_pkg::ST_FULL;
              ovld_d = 1'b1;
            end else begin
              hole_d  = IW'(cnt_q);
              state_d = S_UP_CHK;
            end
          end else if (in_i.operation == kmhq_pkg::OP_EXTRACT ||
                       in_i.operation == kmhq_pkg::OP_PEEK) begin
            if (cnt_q == '0) begin
              ost_d  = kmhq_pkg::ST_EMPTY;
              ovld_d = 1'b1;
            end else begin
              ram_re  = 1'b1;
              state_d = S_RD_ROOT;
            end
          end else begin
            ovld_d = 1'b1;
          end
        end
      end

      // climb: place entry at the root or fetch the parent index
      S_UP_CHK: begin
        if (hole_q == '0) begin
          ram_we  = 1'b1;
          cnt_d   = cnt_q + CW'(1);
          ocnt_d  = kmhq_pkg::COUNT_W'(cnt_q + CW'(1));
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = S_UP_DIV;
        end
      end

      S_UP_DIV: begin
        if (div_done) begin
          ram_re    = 1'b1;
          ram_raddr = div_quot;
          bidx_d    = div_quot;
          state_d   = S_UP_CMP;
        end
      end

      // move the parent down or settle the new entry
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ent_q[EW-1:PAYLOAD_BITS] < ram_rdata[EW-1:PAYLOAD_BITS]) begin
          ram_wdata = ram_rdata;
          hole_d    = bidx_q;
          state_d   = S_UP_CHK;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          ocnt_d  = kmhq_pkg::COUNT_W'(cnt_q + CW'(1));
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      // root read back: report it; for an extract with entries left, fetch the last entry
      S_RD_ROOT: begin
        oent_d = ram_rdata;
        if (op_q == kmhq_pkg::OP_PEEK) begin
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d  = cnt_q - CW'(1);
          ocnt_d = kmhq_pkg::COUNT_W'(cnt_q - CW'(1));
          if (cnt_q == CW'(1)) begin
            ovld_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IW'(cnt_q - CW'(1));
            state_d   = S_RD_LAST;
          end
        end
      end

      S_RD_LAST: begin
        ent_d   = ram_rdata;
        hole_d  = '0;
        state_d = S_DN_GO;
      end

      // first child of the hole
      S_DN_GO: begin
        c_d     = XW'(k_q) * XW'(hole_q) + XW'(1);
        j_d     = '0;
        found_d = 1'b0;
        best_d  = ent_q;
        state_d = S_DN_RD;
      end

      S_DN_RD: begin
        if (j_q == {1'b0, k_q} || c_q >= XW'(cnt_q)) begin
          state_d = S_DN_END;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(c_q);
          state_d   = S_DN_CMP;
        end
      end

      // keep the first strictly smallest child
      S_DN_CMP: begin
        if (ram_rdata[EW-1:PAYLOAD_BITS] < best_q[EW-1:PAYLOAD_BITS]) begin
          best_d  = ram_rdata;
          bidx_d  = IW'(c_q);
          found_d = 1'b1;
        end
        c_d     = c_q + XW'(1);
        j_d     = j_q + (AW+1)'(1);
        state_d = S_DN_RD;
      end

      S_DN_END: begin
        ram_we = 1'b1;
        if (found_q) begin
          ram_wdata = best_q;
          hole_d    = bidx_q;
          state_d   = S_DN_GO;
        end else begin
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      arity_q <= kmhq_pkg::ARITY_RESET;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        arity_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    op_q    <= op_d;
    ent_q   <= ent_d;
    hole_q  <= hole_d;
    c_q     <= c_d;
    j_q     <= j_d;
    found_q <= found_d;
    best_q  <= best_d;
    bidx_q  <= bidx_d;
    ost_q   <= ost_d;
    oent_q  <= oent_d;
    ocnt_q  <= ocnt_d;
  end

  assign in_i.ready        = (state_q == S_IDLE) && !ovld_q;
  assign out_o.valid       = ovld_q;
  assign out_o.status      = ost_q;
  assign out_o.out_key     = oent_q[EW-1:PAYLOAD_BITS];
  assign out_o.out_payload = oent_q[PAYLOAD_BITS-1:0];
  assign out_o.count       = ocnt_q;

endmodule

### design/kmhq_ram.sv
// ----------------------------------------------------------------------------
// kmhq_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module kmhq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/kmhq_div.sv
// ----------------------------------------------------------------------------
// kmhq_div
// Restoring divider, one quotient bit per cycle, for the parent index
// ----------------------------------------------------------------------------
module kmhq_div #(
  parameter int unsigned W  = 10,
  localparam int unsigned DW = kmhq_pkg::ARITY_W,
  localparam int unsigned CW = $clog2(W + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quot_o
);

  logic [W-1:0]  dq_q, dq_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   rem_sh;

  assign rem_sh = {rem_q[DW-1:0], dq_q[W-1]};

  // one shift-subtract step per cycle
  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        dq_d  = {dq_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dq_d  = {dq_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

### design/kmhq_chk.sv
// ----------------------------------------------------------------------------
// kmhq_chk
// Port-level checks for the heap queue, bound to the top level
// ----------------------------------------------------------------------------
module kmhq_chk #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [kmhq_pkg::STAT_W-1:0]    status_i,
  input logic [KEY_BITS-1:0]            out_key_i,
  input logic [PAYLOAD_BITS-1:0]        out_payload_i,
  input logic [kmhq_pkg::COUNT_W-1:0]   count_i
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // one operation in flight: no new beat while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result is pending");

  // an accepted operation takes the block busy
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after acceptance");

  // empty reports carry no entry and a zero count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == kmhq_pkg::ST_EMPTY |->
      count_i == '0 && out_key_i == '0 && out_payload_i == '0)
    else $error("empty status with non-zero fields");

  // full reports show a full count
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == kmhq_pkg::ST_FULL |->
      count_i == kmhq_pkg::COUNT_W'(CAPACITY))
    else $error("full status with wrong count");

endmodule

bind kary_min_heap_queue_top kmhq_chk #(
  .CAPACITY     (CAPACITY),
  .KEY_BITS     (KEY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_kmhq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .out_key_i     (out_o.out_key),
  .out_payload_i (out_o.out_payload),
  .count_i       (out_o.count)
);
